FILE: design/cir_pkg.sv
package cir_pkg;

	// default fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 12;

	// field widths of one word
	localparam int COORD_W = 32;
	localparam int MASS_W  = 25;
	localparam int REST_W  = 13;

	// stream widths, whole bytes
	localparam int IN_W  = 336;
	localparam int OUT_W = 128;

	// width of the denominators fed to the dividers
	localparam int DEN_W = 32;

	localparam logic signed [79:0] S32_MAX_W = 80'sd2147483647;
	localparam logic signed [79:0] S32_MIN_W = -80'sd2147483648;

	// clamp a wide signed value to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX_W) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN_W) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/cir_div.sv
module cir_div #(
	parameter int NW    = 44,
	parameter int DW    = 32,
	parameter int LANES = 1,
	parameter int PW    = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num [LANES],
	input  logic [DW-1:0]        den [LANES],
	input  logic [PW-1:0]        in_pay,
	output logic                 out_valid,
	output logic signed [NW:0]   quot [LANES],
	output logic [PW-1:0]        out_pay
);

	// restoring divider, one quotient bit per stage, magnitude with sign on the side
	logic              vld_s [NW];
	logic [DW-1:0]     rem_s [NW][LANES];
	logic [NW-1:0]     wrk_s [NW][LANES];
	logic [DW-1:0]     den_s [NW][LANES];
	logic              neg_s [NW][LANES];
	logic [PW-1:0]     pay_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stg
		logic [DW-1:0] r_in [LANES];
		logic [NW-1:0] w_in [LANES];
		logic [DW-1:0] d_in [LANES];
		logic          n_in [LANES];
		logic          v_in;
		logic [PW-1:0] p_in;
		logic [DW:0]   t    [LANES];
		logic          ge   [LANES];

		if (k == 0) begin : g_head
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					r_in[l] = '0;
					w_in[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
					d_in[l] = den[l];
					n_in[l] = num[l][NW-1];
				end
				v_in = in_valid;
				p_in = in_pay;
			end
		end else begin : g_body
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					r_in[l] = rem_s[k-1][l];
					w_in[l] = wrk_s[k-1][l];
					d_in[l] = den_s[k-1][l];
					n_in[l] = neg_s[k-1][l];
				end
				v_in = vld_s[k-1];
				p_in = pay_s[k-1];
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				t[l]  = {r_in[l], w_in[l][NW-1]};
				ge[l] = t[l] >= {1'b0, d_in[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= ge[l] ? DW'(t[l] - {1'b0, d_in[l]}) : t[l][DW-1:0];
					wrk_s[k][l] <= {w_in[l][NW-2:0], ge[l]};
					den_s[k][l] <= d_in[l];
					neg_s[k][l] <= n_in[l];
				end
				pay_s[k] <= p_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_pay   = pay_s[NW-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quot[l] = neg_s[NW-1][l] ? -$signed({1'b0, wrk_s[NW-1][l]})
			                         : $signed({1'b0, wrk_s[NW-1][l]});
		end
	end

endmodule

FILE: design/collision_impulse_resolver_core.sv
// collision impulse resolver, one colliding pair of 2d bodies per word
// s_* channel: a word holds both bodies' position, velocity, mass and
//   restitution; it is taken when s_tvalid and s_tready are both high
// m_* channel: velocity changes of both bodies in m_tdata, and m_tuser
//   high when the impulse was applied, low when the bodies separate
//   (then every change is zero)
// depth: mostly set by the 32 stage square root and the two dividers
//   of 32 + FRAC_BITS stages each, one quotient bit per stage
// throughput: one word per cycle while s_tready is high, every stage is registered
// reset: arst_n clears every valid bit, the pipeline comes up empty
// stall: a held result sits in the output register, one more is caught
//   in a skid register; only when the skid is full does the whole
//   pipeline freeze and s_tready drop, nothing is lost or repeated
module collision_impulse_resolver_core #(
	parameter int FRAC_BITS = cir_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x,
	// b_vel_y, a_mass, b_mass, a_restitution, b_restitution, zero fill
	input  logic [cir_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// a_dv_x, a_dv_y, b_dv_x, b_dv_y
	output logic [cir_pkg::OUT_W-1:0]  m_tdata,
	// resolved
	output logic                       m_tuser
);
	import cir_pkg::*;

	localparam int NW = COORD_W + FRAC_BITS;
	localparam logic [31:0] ONE_W = 32'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] rvx;
		logic signed [31:0] rvy;
		logic [MASS_W-1:0]  ma;
		logic [MASS_W-1:0]  mb;
		logic [REST_W-1:0]  e;
	} geo_t;

	typedef struct packed {
		logic signed [31:0] rvx;
		logic signed [31:0] rvy;
		logic [REST_W-1:0]  e;
		logic               lenz;
	} d1_pay_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] inva;
		logic signed [31:0] invb;
	} nrm_t;

	typedef struct packed {
		nrm_t nrm;
		logic res;
		logic sumz;
	} d2_pay_t;

	// input field split
	logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
	logic signed [31:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
	logic [MASS_W-1:0]  a_mass, b_mass;
	logic [REST_W-1:0]  a_restitution, b_restitution;

	assign a_pos_x       = s_tdata[31:0];
	assign a_pos_y       = s_tdata[63:32];
	assign a_vel_x       = s_tdata[95:64];
	assign a_vel_y       = s_tdata[127:96];
	assign b_pos_x       = s_tdata[159:128];
	assign b_pos_y       = s_tdata[191:160];
	assign b_vel_x       = s_tdata[223:192];
	assign b_vel_y       = s_tdata[255:224];
	assign a_mass        = s_tdata[280:256];
	assign b_mass        = s_tdata[305:281];
	assign a_restitution = s_tdata[318:306];
	assign b_restitution = s_tdata[331:319];

	// pipeline advance, frozen only when the skid register is full
	logic en;
	logic skid_vld_q, m_vld_q;
	assign en       = ~skid_vld_q;
	assign s_tready = en;

	// stage 1: differences, mass floor, lesser restitution
	logic        vld_s1;
	geo_t        geo_s1;
	logic signed [32:0] dxw, dyw, rvxw, rvyw;

	assign dxw  = 33'(b_pos_x) - 33'(a_pos_x);
	assign dyw  = 33'(b_pos_y) - 33'(a_pos_y);
	assign rvxw = 33'(b_vel_x) - 33'(a_vel_x);
	assign rvyw = 33'(b_vel_y) - 33'(a_vel_y);

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.dx  <= sat32(80'(dxw));
			geo_s1.dy  <= sat32(80'(dyw));
			geo_s1.rvx <= sat32(80'(rvxw));
			geo_s1.rvy <= sat32(80'(rvyw));
			geo_s1.ma  <= (a_mass == '0) ? MASS_W'(1) : a_mass;
			geo_s1.mb  <= (b_mass == '0) ? MASS_W'(1) : b_mass;
			geo_s1.e   <= (a_restitution < b_restitution) ? a_restitution : b_restitution;
		end
	end

	// stage 2: squares of the separation
	logic               vld_s2;
	geo_t               geo_s2;
	logic [63:0]        sqx_s2, sqy_s2;
	logic signed [63:0] sqx_c, sqy_c;

	assign sqx_c = geo_s1.dx * geo_s1.dx;
	assign sqy_c = geo_s1.dy * geo_s1.dy;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= sqx_c;
			sqy_s2 <= sqy_c;
			geo_s2 <= geo_s1;
		end
	end

	// stage 3: squared length
	logic        vld_s3;
	geo_t        geo_s3;
	logic [63:0] sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= sqx_s2 + sqy_s2;
			geo_s3 <= geo_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// square root, one result bit per stage
	logic        rt_vld_s [32];
	logic [63:0] rt_v_s   [32];
	logic [63:0] rt_r_s   [32];
	geo_t        rt_geo_s [32];

	for (genvar k = 0; k < 32; k++) begin : g_rt
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] v_in, r_in, t;
		logic        vl_in;
		geo_t        g_in;

		if (k == 0) begin : g_head
			assign v_in  = sq_s3;
			assign r_in  = '0;
			assign vl_in = vld_s3;
			assign g_in  = geo_s3;
		end else begin : g_body
			assign v_in  = rt_v_s[k-1];
			assign r_in  = rt_r_s[k-1];
			assign vl_in = rt_vld_s[k-1];
			assign g_in  = rt_geo_s[k-1];
		end

		assign t = r_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= vl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= t) begin
					rt_v_s[k] <= v_in - t;
					rt_r_s[k] <= (r_in >> 1) + BIT;
				end else begin
					rt_v_s[k] <= v_in;
					rt_r_s[k] <= r_in >> 1;
				end
				rt_geo_s[k] <= g_in;
			end
		end
	end

	// first divider: normal parts and both inverse masses
	logic [31:0]          len;
	logic signed [NW-1:0] d1_num [4];
	logic [DEN_W-1:0]     d1_den [4];
	d1_pay_t              d1_pay_i, d1_pay_o;
	logic                 d1_vld;
	logic signed [NW:0]   d1_q   [4];
	geo_t                 geo_r;

	assign geo_r = rt_geo_s[31];
	assign len   = rt_r_s[31][31:0];

	always_comb begin
		d1_num[0] = NW'(geo_r.dx) <<< FRAC_BITS;
		d1_num[1] = NW'(geo_r.dy) <<< FRAC_BITS;
		d1_num[2] = NW'(1) << (2 * FRAC_BITS);
		d1_num[3] = NW'(1) << (2 * FRAC_BITS);
		d1_den[0] = len;
		d1_den[1] = len;
		d1_den[2] = DEN_W'(geo_r.ma);
		d1_den[3] = DEN_W'(geo_r.mb);
		d1_pay_i.rvx  = geo_r.rvx;
		d1_pay_i.rvy  = geo_r.rvy;
		d1_pay_i.e    = geo_r.e;
		d1_pay_i.lenz = (len == '0);
	end

	cir_div #(
		.NW    (NW),
		.DW    (DEN_W),
		.LANES (4),
		.PW    ($bits(d1_pay_t))
	) u_div_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_vld_s[31]),
		.num       (d1_num),
		.den       (d1_den),
		.in_pay    (d1_pay_i),
		.out_valid (d1_vld),
		.quot      (d1_q),
		.out_pay   (d1_pay_o)
	);

	// stage 4: normal and inverse masses clamped
	logic               vld_s4;
	nrm_t               nrm_s4;
	logic signed [31:0] rvx_s4, rvy_s4;
	logic [REST_W-1:0]  e_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s4.nx   <= d1_pay_o.lenz ? 32'sd0 : sat32(80'(d1_q[0]));
			nrm_s4.ny   <= d1_pay_o.lenz ? 32'sd0 : sat32(80'(d1_q[1]));
			nrm_s4.inva <= sat32(80'(d1_q[2]));
			nrm_s4.invb <= sat32(80'(d1_q[3]));
			rvx_s4      <= d1_pay_o.rvx;
			rvy_s4      <= d1_pay_o.rvy;
			e_s4        <= d1_pay_o.e;
		end
	end

	// stage 5: projection products, inverse-mass sum
	logic               vld_s5;
	nrm_t               nrm_s5;
	logic signed [63:0] px_s5, py_s5;
	logic signed [63:0] px_c, py_c;
	logic [32:0]        sum_s5;
	logic [REST_W-1:0]  e_s5;

	assign px_c = rvx_s4 * nrm_s4.nx;
	assign py_c = rvy_s4 * nrm_s4.ny;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5  <= px_c;
			py_s5  <= py_c;
			sum_s5 <= 33'(nrm_s4.inva) + 33'(nrm_s4.invb);
			nrm_s5 <= nrm_s4;
			e_s5   <= e_s4;
		end
	end

	// stage 6: normal velocity
	logic               vld_s6;
	nrm_t               nrm_s6;
	logic signed [31:0] van_s6;
	logic signed [31:0] mx_c, my_c;
	logic [32:0]        sum_s6;
	logic [REST_W-1:0]  e_s6;

	assign mx_c = sat32(80'(px_s5 >>> FRAC_BITS));
	assign my_c = sat32(80'(py_s5 >>> FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			van_s6 <= sat32(80'(mx_c) + 80'(my_c));
			nrm_s6 <= nrm_s5;
			sum_s6 <= sum_s5;
			e_s6   <= e_s5;
		end
	end

	// stage 7: raw impulse product, approach test
	logic               vld_s7;
	nrm_t               nrm_s7;
	logic signed [63:0] pj_s7;
	logic signed [63:0] pj_c;
	logic [31:0]        one_e;
	logic signed [31:0] jneg;
	logic               res_s7;
	logic [32:0]        sum_s7;

	assign one_e = ONE_W + 32'(e_s6);
	assign jneg  = -$signed(one_e);
	assign pj_c  = jneg * van_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pj_s7  <= pj_c;
			res_s7 <= ~(van_s6 > 32'sd0);
			nrm_s7 <= nrm_s6;
			sum_s7 <= sum_s6;
		end
	end

	// stage 8: impulse numerator
	logic               vld_s8;
	nrm_t               nrm_s8;
	logic signed [31:0] j0_s8;
	logic               res_s8;
	logic [32:0]        sum_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			j0_s8  <= sat32(80'(pj_s7 >>> FRAC_BITS));
			res_s8 <= res_s7;
			nrm_s8 <= nrm_s7;
			sum_s8 <= sum_s7;
		end
	end

	// second divider: impulse over inverse-mass sum
	logic signed [NW-1:0] d2_num [1];
	logic [DEN_W-1:0]     d2_den [1];
	d2_pay_t              d2_pay_i, d2_pay_o;
	logic                 d2_vld;
	logic signed [NW:0]   d2_q   [1];

	always_comb begin
		d2_num[0]     = NW'(j0_s8) <<< FRAC_BITS;
		d2_den[0]     = sum_s8[DEN_W-1:0];
		d2_pay_i.nrm  = nrm_s8;
		d2_pay_i.res  = res_s8;
		d2_pay_i.sumz = (sum_s8 == '0);
	end

	cir_div #(
		.NW    (NW),
		.DW    (DEN_W),
		.LANES (1),
		.PW    ($bits(d2_pay_t))
	) u_div_j (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s8),
		.num       (d2_num),
		.den       (d2_den),
		.in_pay    (d2_pay_i),
		.out_valid (d2_vld),
		.quot      (d2_q),
		.out_pay   (d2_pay_o)
	);

	// stage 9: impulse scalar
	logic               vld_s9;
	nrm_t               nrm_s9;
	logic signed [31:0] j_s9;
	logic               res_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			j_s9   <= d2_pay_o.sumz ? 32'sd0 : sat32(80'(d2_q[0]));
			nrm_s9 <= d2_pay_o.nrm;
			res_s9 <= d2_pay_o.res;
		end
	end

	// stage 10: impulse vector products
	logic               vld_s10;
	logic signed [63:0] ixp_s10, iyp_s10;
	logic signed [63:0] ixp_c, iyp_c;
	logic signed [31:0] inva_s10, invb_s10;
	logic               res_s10;

	assign ixp_c = nrm_s9.nx * j_s9;
	assign iyp_c = nrm_s9.ny * j_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ixp_s10  <= ixp_c;
			iyp_s10  <= iyp_c;
			inva_s10 <= nrm_s9.inva;
			invb_s10 <= nrm_s9.invb;
			res_s10  <= res_s9;
		end
	end

	// stage 11: impulse vector and its negation
	logic               vld_s11;
	logic signed [31:0] ix_s11, iy_s11, nix_s11, niy_s11;
	logic signed [31:0] ix_c, iy_c;
	logic signed [31:0] inva_s11, invb_s11;
	logic               res_s11;

	assign ix_c = sat32(80'(ixp_s10 >>> FRAC_BITS));
	assign iy_c = sat32(80'(iyp_s10 >>> FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s11   <= ix_c;
			iy_s11   <= iy_c;
			nix_s11  <= sat32(-80'(ix_c));
			niy_s11  <= sat32(-80'(iy_c));
			inva_s11 <= inva_s10;
			invb_s11 <= invb_s10;
			res_s11  <= res_s10;
		end
	end

	// stage 12: velocity change products
	logic               vld_s12;
	logic signed [63:0] axp_s12, ayp_s12, bxp_s12, byp_s12;
	logic signed [63:0] axp_c, ayp_c, bxp_c, byp_c;
	logic               res_s12;

	assign axp_c = nix_s11 * inva_s11;
	assign ayp_c = niy_s11 * inva_s11;
	assign bxp_c = ix_s11 * invb_s11;
	assign byp_c = iy_s11 * invb_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			axp_s12 <= axp_c;
			ayp_s12 <= ayp_c;
			bxp_s12 <= bxp_c;
			byp_s12 <= byp_c;
			res_s12 <= res_s11;
		end
	end

	// stage 13: final changes, zeroed when separating
	logic              vld_s13;
	logic [OUT_W-1:0]  dat_s13;
	logic              res_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			if (res_s12) begin
				dat_s13 <= {sat32(80'(byp_s12 >>> FRAC_BITS)),
				            sat32(80'(bxp_s12 >>> FRAC_BITS)),
				            sat32(80'(ayp_s12 >>> FRAC_BITS)),
				            sat32(80'(axp_s12 >>> FRAC_BITS))};
			end else begin
				dat_s13 <= '0;
			end
			res_s13 <= res_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s4  <= d1_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= d2_vld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// output register with skid register behind it
	logic             push;
	logic             take;
	logic [OUT_W-1:0] m_dat_q, skid_dat_q;
	logic             m_res_q, skid_res_q;

	assign push = en & vld_s13;
	assign take = ~m_vld_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				m_vld_q    <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				m_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_dat_q <= skid_vld_q ? skid_dat_q : dat_s13;
			m_res_q <= skid_vld_q ? skid_res_q : res_s13;
		end else if (push) begin
			skid_dat_q <= dat_s13;
			skid_res_q <= res_s13;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_dat_q;
	assign m_tuser  = m_res_q;

	// a caught word always has a word waiting ahead of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> m_vld_q)
		else $error("skid register holds a word with the output empty");

	// the skid only fills when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !$past(skid_vld_q) |-> $past(m_vld_q && !m_tready))
		else $error("skid register filled without a stalled output");

	// separating pairs carry no velocity change
	a_sep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q && !m_res_q |-> m_dat_q == '0)
		else $error("non-zero change on a separating pair");

endmodule
